### hw/rtl/orl_pkg.sv
// ----------------------------------------------------------------------------
// orl_pkg: shared definitions of the ordered record list
// Operation and status codes, cell commands and default sizes.
// ----------------------------------------------------------------------------
package orl_pkg;

  localparam int unsigned CAPACITY_DEF     = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;

  typedef enum logic [3:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_REM_FRONT = 4'd3,
    OP_REM_BACK  = 4'd4,
    OP_REM_AT    = 4'd5,
    OP_REM_KEY   = 4'd6,
    OP_FIND      = 4'd7,
    OP_READ_AT   = 4'd8,
    OP_CONTAINS  = 4'd9,
    OP_COUNT     = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_NOKEY = 3'd3,
    ST_RANGE = 3'd4
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] found_key;
    logic [63:0]        found_payload;
    logic [4:0]         match_count;
    logic [4:0]         list_length;
  } rsp_t;

endpackage

### hw/rtl/orl_req_if.sv
// ----------------------------------------------------------------------------
// orl_req_if: request channel of the ordered record list
// Valid/ready channel carrying one list operation per transfer.
// ----------------------------------------------------------------------------
interface orl_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic [4:0]         position;
  logic signed [31:0] record_key;
  logic [63:0]        record_payload;

  modport source (
    output valid, operation, position, record_key, record_payload,
    input  ready
  );
  modport sink (
    input  valid, operation, position, record_key, record_payload,
    output ready
  );
endinterface

### hw/rtl/orl_rsp_if.sv
// ----------------------------------------------------------------------------
// orl_rsp_if: response channel of the ordered record list
// Valid/ready channel carrying one operation result per transfer.
// ----------------------------------------------------------------------------
interface orl_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] found_key;
  logic [63:0]        found_payload;
  logic [4:0]         match_count;
  logic [4:0]         list_length;

  modport source (
    output valid, status, found_key, found_payload, match_count, list_length,
    input  ready
  );
  modport sink (
    input  valid, status, found_key, found_payload, match_count, list_length,
    output ready
  );
endinterface

### hw/rtl/orl_cell.sv
// ----------------------------------------------------------------------------
// orl_cell: one entry of the record chain
// Holds a key and payload and loads from its neighbors, the new record or
// the chain head, as the broadcast command and its own index decide.
// ----------------------------------------------------------------------------
module orl_cell #(
  parameter int unsigned CAPACITY     = orl_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = orl_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned INDEX        = 0,
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1),
  localparam int unsigned PW          = (CNT_W > 5) ? CNT_W : 5
) (
  input  logic                    clk_i,
  input  orl_pkg::cell_op_e       cmd_i,
  input  logic [PW-1:0]           idx_i,
  input  logic signed [31:0]      new_key_i,
  input  logic [PAYLOAD_BITS-1:0] new_pay_i,
  input  logic signed [31:0]      prev_key_i,
  input  logic [PAYLOAD_BITS-1:0] prev_pay_i,
  input  logic signed [31:0]      next_key_i,
  input  logic [PAYLOAD_BITS-1:0] next_pay_i,
  input  logic signed [31:0]      head_key_i,
  input  logic [PAYLOAD_BITS-1:0] head_pay_i,
  output logic signed [31:0]      key_o,
  output logic [PAYLOAD_BITS-1:0] pay_o
);

  localparam logic [PW-1:0] MyIdx = PW'(INDEX);

  logic signed [31:0]      key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    unique case (cmd_i)
      orl_pkg::CELL_INSERT: begin
        if (MyIdx > idx_i) begin
          key_d = prev_key_i;
          pay_d = prev_pay_i;
        end else if (MyIdx == idx_i) begin
          key_d = new_key_i;
          pay_d = new_pay_i;
        end
      end
      orl_pkg::CELL_REMOVE: begin
        if (MyIdx >= idx_i) begin
          key_d = next_key_i;
          pay_d = next_pay_i;
        end
      end
      orl_pkg::CELL_ROTATE: begin
        // The cell at the tail of the valid entries receives the head.
        if (MyIdx < idx_i) begin
          key_d = next_key_i;
          pay_d = next_pay_i;
        end else if (MyIdx == idx_i) begin
          key_d = head_key_i;
          pay_d = head_pay_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

### hw/rtl/ordered_record_list.sv
// ----------------------------------------------------------------------------
// ordered_record_list: fixed-capacity ordered list of keyed records
// A chain of entry cells with a small sequencer that inserts, removes,
// searches, reads and counts, returning one result per operation.
// ----------------------------------------------------------------------------
//
//   channel   port   direction   carries
//   -------   ----   ---------   ---------------------------------------------
//   request   req_i  in          operation, position, record_key, payload
//   response  rsp_o  out         status, found record, match_count, length
//
// Inserts and removal at the front are done at once: the entries from the
// chosen position onward shift by one place together. Every other operation
// rotates the chain through its head cell once, and the head is compared,
// captured or dropped on each step. Operations rejected for a full or empty
// list or a bad position finish without a scan. The result sits in an
// output register until it is taken; a new request is taken once the
// sequencer is idle and that register is free or drained in the same cycle.
// Reset empties the list; entry contents need no clearing.
//
module ordered_record_list #(
  parameter int unsigned CAPACITY     = orl_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = orl_pkg::PAYLOAD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  orl_req_if.sink   req_i,
  orl_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // Positions and lengths are compared at a width that holds both.
  localparam int unsigned PW    = (CNT_W > 5) ? CNT_W : 5;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Number of valid entries.
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Chain of entry cells. Cell 0 is the list head.
  logic signed [31:0]      cell_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_pay [CAPACITY];
  orl_pkg::cell_op_e       cell_cmd;
  logic [PW-1:0]           cell_idx;
  logic [PAYLOAD_BITS-1:0] new_pay;

  assign new_pay = req_i.record_payload[PAYLOAD_BITS-1:0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0]      prev_key, next_key;
    logic [PAYLOAD_BITS-1:0] prev_pay, next_pay;

    if (g == 0) begin : g_first
      assign prev_key = req_i.record_key;
      assign prev_pay = new_pay;
    end else begin : g_mid
      assign prev_key = cell_key[g-1];
      assign prev_pay = cell_pay[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_key = cell_key[g];
      assign next_pay = cell_pay[g];
    end else begin : g_inner
      assign next_key = cell_key[g+1];
      assign next_pay = cell_pay[g+1];
    end

    orl_cell #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .INDEX        (g)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cell_cmd),
      .idx_i      (cell_idx),
      .new_key_i  (req_i.record_key),
      .new_pay_i  (new_pay),
      .prev_key_i (prev_key),
      .prev_pay_i (prev_pay),
      .next_key_i (next_key),
      .next_pay_i (next_pay),
      .head_key_i (cell_key[0]),
      .head_pay_i (cell_pay[0]),
      .key_o      (cell_key[g]),
      .pay_o      (cell_pay[g])
    );
  end

  // Scan context, loaded when a rotating operation is accepted.
  orl_pkg::op_e            op_q, op_d;
  logic signed [31:0]      key_q, key_d;
  logic [PW-1:0]           tgt_q, tgt_d;
  logic [PW-1:0]           step_q, step_d;
  logic [PW-1:0]           last_q, last_d;
  logic                    hit_q, hit_d;
  logic [CNT_W-1:0]        mcnt_q, mcnt_d;
  logic signed [31:0]      fkey_q, fkey_d;
  logic [PAYLOAD_BITS-1:0] fpay_q, fpay_d;

  // Output register.
  logic          rsp_valid_q, rsp_valid_d;
  orl_pkg::rsp_t rsp_q, rsp_d;

  logic [PW-1:0] len_ext, pos_ext;
  logic          full, empty, accept;
  logic          head_match, at_tgt, drop, capture;

  assign len_ext = PW'(cnt_q);
  assign pos_ext = PW'(req_i.position);
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign empty   = (cnt_q == '0);

  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // Per-step decisions on the head cell during a scan.
  assign head_match = (cell_key[0] == key_q);
  assign at_tgt     = (step_q == tgt_q);
  assign drop       = ((op_q == orl_pkg::OP_REM_KEY) && head_match)
                   || (((op_q == orl_pkg::OP_REM_BACK) || (op_q == orl_pkg::OP_REM_AT))
                       && at_tgt);
  assign capture    = ((op_q == orl_pkg::OP_FIND) && head_match && !hit_q)
                   || (((op_q == orl_pkg::OP_REM_BACK) || (op_q == orl_pkg::OP_REM_AT)
                       || (op_q == orl_pkg::OP_READ_AT)) && at_tgt);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cell_cmd    = orl_pkg::CELL_HOLD;
    cell_idx    = '0;
    op_d        = op_q;
    key_d       = key_q;
    tgt_d       = tgt_q;
    step_d      = step_q;
    last_d      = last_q;
    hit_d       = hit_q;
    mcnt_d      = mcnt_q;
    fkey_d      = fkey_q;
    fpay_d      = fpay_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // Unless a scan starts, the result is ready at once.
          rsp_valid_d          = 1'b1;
          rsp_d.status         = orl_pkg::ST_OK;
          rsp_d.found_key      = '0;
          rsp_d.found_payload  = '0;
          rsp_d.match_count    = '0;

          unique case (orl_pkg::op_e'(req_i.operation)) inside
            orl_pkg::OP_INS_FRONT, orl_pkg::OP_INS_BACK, orl_pkg::OP_INS_AT: begin
              if (full) begin
                rsp_d.status = orl_pkg::ST_FULL;
              end else if ((req_i.operation == orl_pkg::OP_INS_AT)
                           && (pos_ext > len_ext)) begin
                rsp_d.status = orl_pkg::ST_RANGE;
              end else begin
                cell_cmd = orl_pkg::CELL_INSERT;
                if (req_i.operation == orl_pkg::OP_INS_FRONT) begin
                  cell_idx = '0;
                end else if (req_i.operation == orl_pkg::OP_INS_BACK) begin
                  cell_idx = len_ext;
                end else begin
                  cell_idx = pos_ext;
                end
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            orl_pkg::OP_REM_FRONT: begin
              if (empty) begin
                rsp_d.status = orl_pkg::ST_EMPTY;
              end else begin
                cell_cmd            = orl_pkg::CELL_REMOVE;
                cell_idx            = '0;
                rsp_d.found_key     = cell_key[0];
                rsp_d.found_payload = 64'(cell_pay[0]);
                cnt_d               = cnt_q - CNT_W'(1);
              end
            end
            orl_pkg::OP_REM_BACK, orl_pkg::OP_REM_AT, orl_pkg::OP_REM_KEY,
            orl_pkg::OP_FIND, orl_pkg::OP_READ_AT, orl_pkg::OP_CONTAINS,
            orl_pkg::OP_COUNT: begin
              if (empty) begin
                // Counting an empty list is a valid answer of zero.
                if (req_i.operation != orl_pkg::OP_COUNT) begin
                  rsp_d.status = orl_pkg::ST_EMPTY;
                end
              end else if (((req_i.operation == orl_pkg::OP_REM_AT)
                            || (req_i.operation == orl_pkg::OP_READ_AT))
                           && (pos_ext >= len_ext)) begin
                rsp_d.status = orl_pkg::ST_RANGE;
              end else begin
                rsp_valid_d = rsp_valid_q && !rsp_o.ready;
                rsp_d       = rsp_q;
                state_d     = S_SCAN;
                op_d        = orl_pkg::op_e'(req_i.operation);
                key_d       = req_i.record_key;
                tgt_d       = (req_i.operation == orl_pkg::OP_REM_BACK)
                            ? (len_ext - PW'(1)) : pos_ext;
                step_d      = '0;
                last_d      = len_ext - PW'(1);
                hit_d       = 1'b0;
                mcnt_d      = '0;
                fkey_d      = '0;
                fpay_d      = '0;
              end
            end
            default: begin
            end
          endcase

          rsp_d.list_length = 5'(cnt_d);
        end
      end

      S_SCAN: begin
        // Each step either drops the head or moves it behind the tail, so
        // after one pass over the original entries the order is restored.
        if (drop) begin
          cell_cmd = orl_pkg::CELL_REMOVE;
          cell_idx = '0;
          cnt_d    = cnt_q - CNT_W'(1);
        end else begin
          cell_cmd = orl_pkg::CELL_ROTATE;
          cell_idx = len_ext - PW'(1);
        end
        hit_d  = hit_q || head_match;
        mcnt_d = mcnt_q + CNT_W'(head_match);
        if (capture) begin
          fkey_d = cell_key[0];
          fpay_d = cell_pay[0];
        end
        step_d = step_q + PW'(1);

        if (step_q == last_q) begin
          state_d             = S_IDLE;
          rsp_valid_d         = 1'b1;
          rsp_d.status        = orl_pkg::ST_OK;
          rsp_d.found_key     = fkey_d;
          rsp_d.found_payload = 64'(fpay_d);
          rsp_d.match_count   = '0;
          rsp_d.list_length   = 5'(cnt_d);
          if ((op_q == orl_pkg::OP_REM_KEY) || (op_q == orl_pkg::OP_COUNT)) begin
            rsp_d.match_count = 5'(mcnt_d);
          end
          if (((op_q == orl_pkg::OP_REM_KEY) || (op_q == orl_pkg::OP_FIND)
               || (op_q == orl_pkg::OP_CONTAINS)) && !hit_d) begin
            rsp_d.status = orl_pkg::ST_NOKEY;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    tgt_q  <= tgt_d;
    step_q <= step_d;
    last_q <= last_d;
    hit_q  <= hit_d;
    mcnt_q <= mcnt_d;
    fkey_q <= fkey_d;
    fpay_q <= fpay_d;
    rsp_q  <= rsp_d;
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_q.status;
  assign rsp_o.found_key     = rsp_q.found_key;
  assign rsp_o.found_payload = rsp_q.found_payload;
  assign rsp_o.match_count   = rsp_q.match_count;
  assign rsp_o.list_length   = rsp_q.list_length;

endmodule

### hw/rtl/orl_checker.sv
// ----------------------------------------------------------------------------
// orl_checker: port-level checks of the ordered record list
// Watches the response channel for results that cannot occur.
// ----------------------------------------------------------------------------
module orl_checker #(
  parameter int unsigned CAPACITY = orl_pkg::CAPACITY_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  orl_req_if.sink   req_i,
  orl_rsp_if.source rsp_o
);

  // No result ever reports more entries than the list can hold.
  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (int'(rsp_o.list_length) <= CAPACITY))
    else $error("list length above capacity");

  // An insert rejected for a full list reports no record and no matches.
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == orl_pkg::ST_FULL)) |->
      ((rsp_o.found_key == '0) && (rsp_o.found_payload == '0)
       && (rsp_o.match_count == '0)))
    else $error("full status with record data");

  // A missing key always comes with a zero match count.
  a_nokey_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == orl_pkg::ST_NOKEY)) |->
      (rsp_o.match_count == '0))
    else $error("key not found with nonzero match count");

  // A result waiting for the sink stays valid and keeps its status, record and length.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=>
      (rsp_o.valid && $stable(rsp_o.status) && $stable(rsp_o.found_key)
       && $stable(rsp_o.found_payload) && $stable(rsp_o.list_length)))
    else $error("response changed while stalled");

  // A request transfer never coincides with a stalled result.
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while the result is stalled");

endmodule

bind ordered_record_list orl_checker #(
  .CAPACITY (CAPACITY)
) u_orl_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);
